// ----- rtl/core/lrucd_pkg.sv -----
// shared types and constants of the lru line cache directory
package lrucd_pkg;
  localparam int unsigned SlotsDef = 64;
  localparam int unsigned TagBitsDef = 16;
  localparam int unsigned AddrBitsDef = 28;
  localparam int unsigned KindW = 2;
  localparam int unsigned LineTagW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned SlotAddrW = 18;
  localparam int unsigned DataAddrW = 19;
  localparam int unsigned CountW = 32;

  typedef enum logic [KindW-1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_REMOTE = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_SHIFT   = 1'b0,
    REG_SLOTS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SEEN, ST_SCAN, ST_WAIT, ST_DONE, ST_AGE, ST_AGE_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrBitsDef-1:0] address;
    logic [LineTagW-1:0] line_tag;
  } in_word_t;

  typedef struct packed {
    logic status;
    logic hit;
    logic [SlotAddrW-1:0] slot_address;
    logic [DataAddrW-1:0] data_address;
    logic fetch_line;
    logic zero_fill;
    logic write_back;
    logic [LineTagW-1:0] victim_tag;
    logic [SlotAddrW-1:0] victim_slot_address;
    logic send_remote;
    logic [CountW-1:0] access_total;
    logic [CountW-1:0] miss_total;
  } out_word_t;
endpackage

// ----- rtl/core/lrucd_stream_if.sv -----
// valid/ready channel carrying one word
interface lrucd_stream_if #(parameter type word_t = logic);
  logic valid;
  logic ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lrucd_ram.sv -----
// generic single port ram with registered read
module lrucd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- rtl/core/lru_line_cache_directory.sv -----
// lru line cache directory top level: slot table sequencer
// per word: a tag scan, then an age pass with a read and a write per slot
// a remote write or out-of-range tag runs the tag scan only and skips the age pass
// one word at a time: a new word is taken only once the previous result has been accepted
// reset: slot valid/dirty flops and counters clear at once; a clearing pass
// sweeps the seen-tag ram before the first word is taken
module lru_line_cache_directory import lrucd_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDef,
  parameter int unsigned TAG_BITS = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lrucd_stream_if.sink        in_if,
  lrucd_stream_if.source      out_if
);
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS+1);
  localparam int unsigned SEENW = (TAG_BITS > 5) ? TAG_BITS-5 : 1;
  localparam int unsigned SEEND = 2**SEENW;

  // configuration
  logic [3:0] shift_q;
  logic [6:0] siu_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 4'd6;
      siu_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_SHIFT: shift_q <= cfg_data_i[3:0];
        REG_SLOTS_IN_USE: siu_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  logic [3:0] shift;
  logic [CW-1:0] cap;
  assign shift = (shift_q < 4'd3) ? 4'd3 : ((shift_q > 4'd12) ? 4'd12 : shift_q);
  always_comb begin
    if (siu_q == 7'd0) cap = CW'(1);
    else if (32'(siu_q) > SLOTS) cap = CW'(SLOTS);
    else cap = CW'(siu_q);
  end

  // slot tag+age ram and flop state
  logic ram_we;
  logic [SW-1:0] ram_addr;
  logic [TAG_BITS+SW-1:0] ram_wdata, ram_rdata;
  lrucd_ram #(.Width(TAG_BITS+SW), .Depth(SLOTS)) u_slot_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata));

  logic seen_we;
  logic [SEENW-1:0] seen_addr;
  logic [31:0] seen_wdata, seen_rdata;
  lrucd_ram #(.Width(32), .Depth(SEEND)) u_seen_ram (
    .clk_i, .we_i(seen_we), .addr_i(seen_addr), .wdata_i(seen_wdata), .rdata_o(seen_rdata));

  logic [SLOTS-1:0] valid_q, dirty_q;
  logic [CW-1:0] free_q;
  logic [CountW-1:0] acc_q, miss_q;
  state_e state_q, state_d;
  logic [SW:0] idx_q;         // sweep index, top bit marks end
  logic [SEENW:0] clr_q;
  in_word_t in_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [11:0] off_q;
  logic known_q, hit_q, oor_q;
  logic [SW-1:0] hs_q, old_q, vic_q;
  logic [SW-1:0] vage_q;
  logic vfound_q, newslot_q;
  logic [SW:0] limit_q;       // ages below limit get bumped
  logic [TAG_BITS-1:0] vic_tag_q;
  out_word_t res_q;
  logic res_v_q;

  // tag of the incoming word
  logic [AddrBitsDef-1:0] ashift;
  logic [LineTagW-1:0] ltag;
  assign ashift = in_q.address >> shift;
  assign ltag = in_q.line_tag;
  logic kind_addr;
  assign kind_addr = (in_q.kind == KIND_READ) || (in_q.kind == KIND_WRITE);
  logic oor_now;
  always_comb begin
    if (kind_addr) oor_now = (64'(ashift) >> TAG_BITS) != 64'd0;
    else oor_now = (64'(ltag) >> TAG_BITS) != 64'd0;
  end

  // scan read pipeline: idx_q issued, data arrives next cycle
  logic [SW:0] ridx_q;
  logic rv_q;
  logic [TAG_BITS-1:0] rtag;
  logic [SW-1:0] rage;
  assign rtag = ram_rdata[TAG_BITS+SW-1:SW];
  assign rage = ram_rdata[SW-1:0];
  logic [SW-1:0] ridx;
  assign ridx = ridx_q[SW-1:0];

  logic [SW-1:0] sel_slot;
  assign sel_slot = hit_q ? hs_q : (newslot_q ? free_q[SW-1:0] : vic_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q[SEENW]) state_d = ST_IDLE;
      ST_IDLE: if (in_if.valid && !res_v_q) state_d = ST_SEEN;
      ST_SEEN: state_d = ST_SCAN;
      ST_SCAN: if (idx_q[SW]) state_d = ST_WAIT;
      ST_WAIT: state_d = ST_DONE;
      ST_DONE: state_d = (oor_q || in_q.kind == KIND_REMOTE) ? ST_OUT : ST_AGE;
      ST_AGE: if (idx_q[SW]) state_d = ST_AGE_WAIT;
      ST_AGE_WAIT: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // age update of the slot under read
  logic bump;
  assign bump = rv_q && valid_q[ridx] && (ridx != sel_slot) && ({1'b0, rage} < limit_q);
  logic do_hot;
  assign do_hot = !(hit_q && in_q.kind != KIND_READ);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx_q[SW-1:0];
    ram_wdata = ram_rdata;
    seen_we = 1'b0;
    seen_addr = SEENW'(tag_q >> 5);
    seen_wdata = seen_rdata | (32'd1 << tag_q[4:0]);
    unique case (state_q)
      ST_CLEAR: begin
        seen_we = 1'b1;
        seen_addr = clr_q[SEENW-1:0];
        seen_wdata = '0;
      end
      ST_AGE: begin
        if (rv_q && do_hot) begin
          ram_addr = ridx;
          if (ridx == sel_slot) begin
            ram_we = 1'b1;
            ram_wdata = {tag_q, SW'(0)};
          end else if (bump) begin
            ram_we = 1'b1;
            ram_wdata = {rtag, rage + SW'(1)};
          end
        end
      end
      ST_AGE_WAIT: begin
        if (rv_q && do_hot) begin
          ram_addr = ridx;
          if (ridx == sel_slot) begin
            ram_we = 1'b1;
            ram_wdata = {tag_q, SW'(0)};
          end else if (bump) begin
            ram_we = 1'b1;
            ram_wdata = {rtag, rage + SW'(1)};
          end
        end
      end
      ST_OUT: seen_we = !oor_q && (in_q.kind == KIND_REMOTE || !hit_q);
      default: ;
    endcase
  end

  assign in_if.ready = (state_q == ST_IDLE) && !res_v_q;
  assign out_if.valid = res_v_q;
  assign out_if.data = res_q;

  // age read alternates: read cycle then write cycle per slot
  logic age_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      idx_q <= '0;
      ridx_q <= '0;
      rv_q <= 1'b0;
      valid_q <= '0;
      dirty_q <= '0;
      free_q <= '0;
      acc_q <= '0;
      miss_q <= '0;
      res_v_q <= 1'b0;
      age_ph_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) res_v_q <= 1'b0;
      rv_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          if (in_if.valid && !res_v_q) in_q <= in_if.data;
          idx_q <= '0;
        end
        ST_SEEN: begin
          oor_q <= oor_now;
          tag_q <= kind_addr ? TAG_BITS'(ashift) : TAG_BITS'(ltag);
          off_q <= 12'(in_q.address & ((AddrBitsDef'(1) << shift) - 1'b1));
          hit_q <= 1'b0;
          vfound_q <= 1'b0;
          vic_q <= '0;
          vage_q <= '0;
          idx_q <= idx_q + 1'b1;
          ridx_q <= idx_q;
          rv_q <= 1'b1;
        end
        ST_SCAN, ST_WAIT: begin
          if (!idx_q[SW]) begin
            idx_q <= idx_q + 1'b1;
            rv_q <= 1'b1;
          end
          ridx_q <= idx_q;
          // seen word for the new tag is on the read port once the scan index reaches 2
          if (state_q == ST_SCAN && idx_q == (SW+1)'(2)) known_q <= seen_rdata[tag_q[4:0]];
          if (rv_q && valid_q[ridx]) begin
            if (rtag == tag_q && !hit_q) begin
              hit_q <= 1'b1;
              hs_q <= ridx;
              old_q <= rage;
            end
            if (!vfound_q || rage > vage_q) begin
              vfound_q <= 1'b1;
              vic_q <= ridx;
              vage_q <= rage;
            end
          end
        end
        ST_DONE: begin
          newslot_q <= !hit_q && (free_q < cap);
          if (hit_q) limit_q <= {1'b0, old_q};
          else if (free_q < cap) limit_q <= (SW+1)'(SLOTS);
          else limit_q <= vfound_q ? {1'b0, vage_q} : (SW+1)'(SLOTS);
          idx_q <= '0;
          age_ph_q <= 1'b0;
        end
        ST_AGE: begin
          age_ph_q <= ~age_ph_q;
          // no read past the last slot
          if (!age_ph_q) begin
            if (!idx_q[SW]) begin
              ridx_q <= idx_q;
              rv_q <= 1'b1;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_OUT: begin
          res_v_q <= 1'b1;
          res_q <= '0;
          if (oor_q) begin
            res_q.status <= 1'b1;
            res_q.access_total <= acc_q;
            res_q.miss_total <= miss_q;
          end else if (in_q.kind == KIND_REMOTE) begin
            res_q.send_remote <= 1'b1;
            res_q.access_total <= acc_q;
            res_q.miss_total <= miss_q;
          end else begin
            res_q.hit <= hit_q;
            res_q.slot_address <= SlotAddrW'(32'(sel_slot) << shift);
            res_q.data_address <= DataAddrW'((32'(sel_slot) << shift) +
                                  ((in_q.kind == KIND_INSERT) ? 32'd0 : 32'(off_q)));
            res_q.access_total <= acc_q + ((in_q.kind == KIND_READ) ? 32'd1 : 32'd0);
            res_q.miss_total <= miss_q + ((in_q.kind == KIND_READ && !hit_q) ? 32'd1 : 32'd0);
            if (in_q.kind == KIND_READ) acc_q <= acc_q + 1'b1;
            if (hit_q) begin
              if (in_q.kind != KIND_READ) dirty_q[hs_q] <= 1'b1;
            end else begin
              if (newslot_q) free_q <= free_q + 1'b1;
              else if (vfound_q && dirty_q[vic_q]) begin
                res_q.write_back <= 1'b1;
                res_q.victim_tag <= LineTagW'(vic_tag_q);
                res_q.victim_slot_address <= SlotAddrW'(32'(vic_q) << shift);
              end
              valid_q[sel_slot] <= 1'b1;
              dirty_q[sel_slot] <= (in_q.kind != KIND_READ);
              if (in_q.kind == KIND_READ) begin
                miss_q <= miss_q + 1'b1;
                res_q.fetch_line <= 1'b1;
              end else if (in_q.kind == KIND_WRITE) begin
                res_q.fetch_line <= known_q;
                res_q.zero_fill <= !known_q;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // victim tag captured during scan
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN || state_q == ST_WAIT) && rv_q && valid_q[ridx] &&
        (!vfound_q || rage > vage_q)) vic_tag_q <= rtag;
  end
endmodule

// ----- rtl/core/lrucd_checker.sv -----
// port-level checker for the lru line cache directory
module lrucd_checker import lrucd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out dropped");
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status |-> !out_data.hit && !out_data.write_back)
    else $error("status word not clean");
  a_fill_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data.fetch_line && out_data.zero_fill)) else $error("fetch and zero");
  a_miss_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.hit |-> !out_data.fetch_line && !out_data.zero_fill)
    else $error("hit with fill");
  // one word in flight: input closes right after a word is taken
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second word taken");
endmodule

bind lru_line_cache_directory lrucd_checker u_lrucd_checker (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data));

// ----- dv/tb_lru_line_cache_directory.sv -----
// testbench of the lru line cache directory: directed table, random phases, scoreboard
module tb_lru_line_cache_directory;
  import lrucd_pkg::*;

  localparam int unsigned NSLOT = SlotsDef;
  localparam int unsigned LIMIT = 3_000_000;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned NPHASE = 14;
  localparam int unsigned SETTLE = 2 * NSLOT + 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  lrucd_stream_if #(.word_t(in_word_t)) in_ch ();
  lrucd_stream_if #(.word_t(out_word_t)) out_ch ();

  lru_line_cache_directory dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the directory state
  bit        known_tag [65536];
  bit [15:0] line_of   [NSLOT];
  bit        held      [NSLOT];
  bit        modified  [NSLOT];
  int        rank      [NSLOT];
  int        claimed;
  bit [31:0] reads_seen;
  bit [31:0] misses_seen;
  bit [3:0]  shift_reg;
  bit [6:0]  pool_reg;

  out_word_t pending_words[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int hits_out = 0;
  int evictions_out = 0;
  int cycles = 0;
  bit gapless_send = 1'b0;
  bit gapless_recv = 1'b0;

  // one line per mismatch
  task automatic report(string field, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch word %0d %s: got %0h want %0h", words_out, field, got, want);
  endtask

  // make slot s the most recent, keeping ranks of held slots a permutation
  function automatic void promote(int s);
    int lim;
    lim = held[s] ? rank[s] : NSLOT;
    for (int j = 0; j < NSLOT; j++)
      if (j != s && held[j] && rank[j] < lim) rank[j]++;
    rank[s] = 0;
    held[s] = 1'b1;
  endfunction

  // choose a slot for a new line: free slot first, else the least recent one
  function automatic int claim_slot(bit [15:0] t, int sh, ref out_word_t r);
    int cap;
    int s;
    cap = (pool_reg < 1) ? 1 : ((pool_reg > NSLOT) ? NSLOT : pool_reg);
    s = 0;
    if (claimed < cap) begin
      s = claimed;
      claimed++;
      held[s] = 1'b0;
    end else begin
      for (int j = 0; j < NSLOT; j++)
        if (held[j] && (!held[s] || rank[j] > rank[s])) s = j;
      if (held[s] && modified[s]) begin
        r.write_back = 1'b1;
        r.victim_tag = line_of[s];
        r.victim_slot_address = SlotAddrW'(s << sh);
      end
    end
    promote(s);
    line_of[s] = t;
    modified[s] = 1'b0;
    known_tag[t] = 1'b1;
    return s;
  endfunction

  // directory behavior for one word
  function automatic out_word_t lookup(in_word_t w);
    out_word_t r;
    int sh;
    longint unsigned tg;
    longint unsigned off;
    bit [15:0] t;
    int s;
    bit hit;
    bit known;
    r = '0;
    off = 0;
    sh = (shift_reg < 3) ? 3 : ((shift_reg > 12) ? 12 : shift_reg);
    if (w.kind == KIND_READ || w.kind == KIND_WRITE) begin
      tg = longint'(w.address) >> sh;
      off = longint'(w.address) & ((64'd1 << sh) - 1);
    end else begin
      tg = w.line_tag;
    end
    if ((tg >> 16) != 0) begin
      r.status = 1'b1; // tag too wide: nothing changes
    end else begin
      t = tg[15:0];
      if (w.kind == KIND_REMOTE) begin
        known_tag[t] = 1'b1;
        r.send_remote = 1'b1;
      end else begin
        s = -1;
        for (int j = 0; j < NSLOT; j++)
          if (s < 0 && held[j] && line_of[j] == t) s = j;
        hit = (s >= 0);
        known = known_tag[t];
        if (w.kind == KIND_READ) reads_seen++;
        if (hit) begin
          // only read hits refresh the order
          if (w.kind == KIND_READ) promote(s);
          else modified[s] = 1'b1;
        end else begin
          s = claim_slot(t, sh, r);
          if (w.kind == KIND_READ) begin
            misses_seen++;
            r.fetch_line = 1'b1;
          end else begin
            modified[s] = 1'b1;
            if (w.kind == KIND_WRITE) begin
              if (known) r.fetch_line = 1'b1;
              else r.zero_fill = 1'b1;
            end
          end
        end
        r.hit = hit;
        r.slot_address = SlotAddrW'(s << sh);
        r.data_address = DataAddrW'((longint'(s) << sh) + ((w.kind == KIND_INSERT) ? 0 : off));
      end
    end
    r.access_total = reads_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(cfg_reg_e idx, bit [6:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LINE_SHIFT) shift_reg = val[3:0];
    else pool_reg = val;
  endtask

  // offer one word, wait for acceptance; caller stands at a falling edge
  task automatic offer(in_word_t w, bit typed, out_word_t want);
    int gap;
    out_word_t calc;
    gap = gapless_send ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    calc = lookup(w);
    pending_words.push_back(typed ? want : calc);
    words_in++;
    @(negedge clk_i);
  endtask

  // wait for the directory to drain before touching registers
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off so the input backs up
  initial begin
    int stall;
    bit held_off;
    held_off = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gapless_recv ? 0 : $urandom_range(0, 19);
      if (!held_off && words_out == 300) begin
        held_off = 1'b1;
        stall = 600;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // scoreboard: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_words.size() == 0) begin
        report("unexpected word", got, 0);
      end else begin
        want = pending_words.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.hit != want.hit) report("hit", got.hit, want.hit);
        if (got.slot_address != want.slot_address)
          report("slot_address", got.slot_address, want.slot_address);
        if (got.data_address != want.data_address)
          report("data_address", got.data_address, want.data_address);
        if (got.fetch_line != want.fetch_line)
          report("fetch_line", got.fetch_line, want.fetch_line);
        if (got.zero_fill != want.zero_fill)
          report("zero_fill", got.zero_fill, want.zero_fill);
        if (got.write_back != want.write_back)
          report("write_back", got.write_back, want.write_back);
        if (got.victim_tag != want.victim_tag)
          report("victim_tag", got.victim_tag, want.victim_tag);
        if (got.victim_slot_address != want.victim_slot_address)
          report("victim_slot_address", got.victim_slot_address, want.victim_slot_address);
        if (got.send_remote != want.send_remote)
          report("send_remote", got.send_remote, want.send_remote);
        if (got.access_total != want.access_total)
          report("access_total", got.access_total, want.access_total);
        if (got.miss_total != want.miss_total)
          report("miss_total", got.miss_total, want.miss_total);
      end
      words_out++;
      if (got.hit) hits_out++;
      if (got.write_back) evictions_out++;
    end
  end

  // watchdog, sized for the slowest legal run several times over
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, pending_words.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    kind_e     kind;
    bit [27:0] address;
    bit [15:0] line_tag;
    bit        typed;
    out_word_t want;
  } step_t;

  step_t steps[$];

  initial begin
    in_word_t w;
    int pool_base;
    int pool_span;
    int pick;
    int sh;
    bit [15:0] t;
    bit [6:0] shift_val [NPHASE];
    bit [6:0] slots_val [NPHASE];

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int j = 0; j < 65536; j++) known_tag[j] = 1'b0;
    for (int j = 0; j < NSLOT; j++) begin
      held[j] = 1'b0;
      modified[j] = 1'b0;
      rank[j] = 0;
      line_of[j] = '0;
    end
    claimed = 0;
    reads_seen = '0;
    misses_seen = '0;
    shift_reg = 4'd6;
    pool_reg = 7'd64;

    // directed rows at reset settings (64 byte lines, 64 slots)
    // fields of want: status hit slot data fetch zero wb vtag vslot send acc miss
    steps.push_back('{KIND_READ, 28'h40, 16'h0, 1'b1,
                      '{1'b0, 1'b0, 18'd0, 19'd0, 1'b1, 1'b0, 1'b0, 16'd0, 18'd0, 1'b0, 32'd1, 32'd1}});
    // read hit at byte 7, order refresh
    steps.push_back('{KIND_READ, 28'h47, 16'h0, 1'b1,
                      '{1'b0, 1'b1, 18'd0, 19'd7, 1'b0, 1'b0, 1'b0, 16'd0, 18'd0, 1'b0, 32'd2, 32'd1}});
    // word write to a never known tag: zero fill
    steps.push_back('{KIND_WRITE, 28'h80, 16'h0, 1'b1,
                      '{1'b0, 1'b0, 18'd64, 19'd64, 1'b0, 1'b1, 1'b0, 16'd0, 18'd0, 1'b0, 32'd2, 32'd1}});
    // remote write only marks the tag known
    steps.push_back('{KIND_REMOTE, 28'h0, 16'h3, 1'b1,
                      '{1'b0, 1'b0, 18'd0, 19'd0, 1'b0, 1'b0, 1'b0, 16'd0, 18'd0, 1'b1, 32'd2, 32'd1}});
    // word write to a known tag: fetch
    steps.push_back('{KIND_WRITE, 28'hC8, 16'h0, 1'b1,
                      '{1'b0, 1'b0, 18'd128, 19'd136, 1'b1, 1'b0, 1'b0, 16'd0, 18'd0, 1'b0, 32'd2, 32'd1}});
    // line insert: no fetch, offset dropped
    steps.push_back('{KIND_INSERT, 28'hFFF_FFFF, 16'h4, 1'b1,
                      '{1'b0, 1'b0, 18'd192, 19'd192, 1'b0, 1'b0, 1'b0, 16'd0, 18'd0, 1'b0, 32'd2, 32'd1}});
    // tag wider than 16 bits: ignored, counts unchanged
    steps.push_back('{KIND_READ, 28'hFFF_FFFF, 16'hFFFF, 1'b1,
                      '{1'b0 | 1'b1, 1'b0, 18'd0, 19'd0, 1'b0, 1'b0, 1'b0, 16'd0, 18'd0, 1'b0, 32'd2, 32'd1}});
    steps.push_back('{KIND_WRITE, 28'hFFF_FFFF, 16'h0, 1'b1,
                      '{1'b1, 1'b0, 18'd0, 19'd0, 1'b0, 1'b0, 1'b0, 16'd0, 18'd0, 1'b0, 32'd2, 32'd1}});
    // rows below rely on the predictor
    steps.push_back('{KIND_INSERT, 28'h0, 16'hFFFF, 1'b0, '0});
    steps.push_back('{KIND_WRITE, 28'h3F_FFFF, 16'h0, 1'b0, '0});   // hit on the top tag
    steps.push_back('{KIND_READ, 28'h3F_FFF8, 16'h0, 1'b0, '0});
    steps.push_back('{KIND_READ, 28'h0, 16'h0, 1'b0, '0});          // tag zero
    steps.push_back('{KIND_REMOTE, 28'h0, 16'hFFFF, 1'b0, '0});
    steps.push_back('{KIND_INSERT, 28'h0, 16'h1, 1'b0, '0});        // insert hit sets dirty
    steps.push_back('{KIND_WRITE, 28'h40, 16'h0, 1'b0, '0});
    steps.push_back('{KIND_READ, 28'h80, 16'h0, 1'b0, '0});
    steps.push_back('{KIND_REMOTE, 28'hFFF_FFFF, 16'h0, 1'b0, '0});

    // phase settings: small pools first since claimed slots never return
    shift_val = '{7'd3, 7'd12, 7'd0, 7'h7F, 7'd7, 7'd9, 7'd4, 7'd5, 7'd8, 7'd10,
                  7'd11, 7'd6, 7'd15, 7'd3};
    slots_val = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd8, 7'd127, 7'd64, 7'd20, 7'd40, 7'd64,
                  7'd5, 7'd64, 7'd100, 7'd64};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the block sits in its seen-tag clearing pass; the handshake waits it out
    foreach (steps[i]) begin
      w.kind = steps[i].kind;
      w.address = steps[i].address;
      w.line_tag = steps[i].line_tag;
      offer(w, steps[i].typed, steps[i].want);
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      drain();
      write_reg(REG_LINE_SHIFT, (ph < 12) ? shift_val[ph] : 7'($urandom_range(0, 127)));
      write_reg(REG_SLOTS_IN_USE, slots_val[ph]);
      gapless_send = (ph % 4 == 1);
      gapless_recv = (ph % 4 == 2) || (ph % 4 == 1);
      sh = (shift_reg < 3) ? 3 : ((shift_reg > 12) ? 12 : shift_reg);
      pool_base = $urandom_range(0, 65535);
      pool_span = $urandom_range(2, (ph % 2) ? 12 : 90);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        w.kind = kind_e'($urandom_range(0, 3));
        w.address = 28'($urandom);
        w.line_tag = 16'($urandom);
        pick = $urandom_range(0, 99);
        t = 16'(pool_base + $urandom_range(0, pool_span - 1));
        if (pick < 88) begin
          // well formed: tag from a small working set, random offset
          w.line_tag = t;
          w.address = 28'((longint'(t) << sh) | (longint'($urandom) & ((64'd1 << sh) - 1)));
        end
        offer(w, 1'b0, '0);
      end
    end

    drain();
    $display("sent %0d words, checked %0d results: %0d hits, %0d dirty evictions",
             words_in, words_out, hits_out, evictions_out);
    $display("line sizes 8 to 4096 bytes, pools of 1 to 64 slots, one long output stall");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lrucd_pkg.sv
rtl/core/lrucd_stream_if.sv
rtl/core/lrucd_ram.sv
rtl/core/lru_line_cache_directory.sv
rtl/core/lrucd_checker.sv
dv/tb_lru_line_cache_directory.sv
